// ----- sv/ab_slot_record_validator_macros.svh -----
// ----------------------------------------------------------------------------
// ab slot record validator assertion macros
// shared property forms for the validator checks
// ----------------------------------------------------------------------------
`ifndef AB_SLOT_RECORD_VALIDATOR_MACROS_SVH
`define AB_SLOT_RECORD_VALIDATOR_MACROS_SVH

// same-cycle implication
`define ABV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define ABV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- sv/abv_pkg.sv -----
// ----------------------------------------------------------------------------
// abv_pkg
// shared types, constants and the crc helper of the slot record validator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package abv_pkg;

  localparam int unsigned SlotBytesDef = 4096;

  localparam int unsigned LimitW = 13;
  localparam int unsigned PosW   = 13;
  localparam int unsigned LenW   = 12;
  localparam int unsigned SeqW   = 32;
  localparam int unsigned CrcW   = 16;

  typedef logic [PosW-1:0]   pos_t;
  typedef logic [LenW-1:0]   len_t;
  typedef logic [SeqW-1:0]   seq_t;
  typedef logic [CrcW-1:0]   crc_t;
  typedef logic [LimitW-1:0] limit_t;

  localparam crc_t   CrcPoly   = 16'h1021;
  localparam limit_t LimitCap  = 13'd4096;
  localparam limit_t LimitRst  = 13'd4096;
  localparam logic [7:0] MagicB     = 8'h42;
  localparam logic [7:0] MagicC     = 8'h43;
  localparam logic [7:0] HdrVersion = 8'h01;

  // header byte offsets
  localparam pos_t PosMagic0   = 13'd0;
  localparam pos_t PosMagic1   = 13'd1;
  localparam pos_t PosVersion  = 13'd2;
  localparam pos_t PosSeqFirst = 13'd4;
  localparam pos_t PosSeqLast  = 13'd7;
  localparam pos_t PosLenLo    = 13'd8;
  localparam pos_t PosLenHi    = 13'd9;
  localparam pos_t PosCrcLo    = 13'd10;
  localparam pos_t PosCrcHi    = 13'd11;
  localparam pos_t HeaderBytes = 13'd12;
  // last payload byte sits at header + length - 1
  localparam pos_t PayloadEndOff = 13'd11;

  typedef struct packed {
    logic clear;
    logic done;
    logic ok;
    logic slot;
    seq_t seq;
    len_t len;
  } verdict_t;

  typedef struct packed {
    logic any;
    logic slot;
    seq_t seq;
    len_t len;
    logic wr_slot;
    seq_t wr_seq;
  } pick_t;

  // crc-16, poly 0x1021, msb first, one byte
  function automatic crc_t crc16_byte(input crc_t crc, input logic [7:0] b);
    crc_t c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[CrcW-1] ? ({c[CrcW-2:0], 1'b0} ^ CrcPoly) : {c[CrcW-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/abv_hdr_parser.sv -----
// ----------------------------------------------------------------------------
// abv_hdr_parser
// per-byte header parse, payload crc and verdict of the current slot
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module abv_hdr_parser #(
  parameter int unsigned SLOT_BYTES = abv_pkg::SlotBytesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        data_i,
  input  wire logic              start_i,
  input  wire logic              idx_i,
  input  wire abv_pkg::limit_t   limit_i,
  output abv_pkg::verdict_t      verdict_o
);
  import abv_pkg::*;

  localparam logic [16:0] MaxLen = 17'(SLOT_BYTES - 32'(HeaderBytes));

  pos_t pos_q, pos_d, pos_e;
  crc_t crc_q, crc_d, crc_e, crc_new;
  seq_t seq_q, seq_d, seq_e;
  len_t len_q, len_d, len_e;
  crc_t hcrc_q, hcrc_d, hcrc_e;
  logic judged_q, judged_d, judged_e;
  logic slot_q, slot_d, slot_e;
  logic fail, pass;
  logic [15:0] len16;
  limit_t lim;

  always_comb begin
    // a start restarts the parse with this byte as byte 0
    pos_e    = start_i ? '0 : pos_q;
    crc_e    = start_i ? '0 : crc_q;
    seq_e    = start_i ? '0 : seq_q;
    len_e    = start_i ? '0 : len_q;
    hcrc_e   = start_i ? '0 : hcrc_q;
    judged_e = start_i ? 1'b0 : judged_q;
    slot_e   = start_i ? idx_i : slot_q;

    pos_d  = pos_e;
    crc_d  = crc_e;
    seq_d  = seq_e;
    len_d  = len_e;
    hcrc_d = hcrc_e;
    fail   = 1'b0;
    pass   = 1'b0;

    len16   = {data_i, len_e[7:0]};
    lim     = (limit_i > LimitCap) ? LimitCap : limit_i;
    crc_new = crc16_byte(crc_e, data_i);

    if (!judged_e) begin
      case (pos_e)
        PosMagic0:  fail = (data_i != MagicB);
        PosMagic1:  fail = (data_i != MagicC);
        PosVersion: fail = (data_i != HdrVersion);
        PosLenLo:   len_d = {4'h0, data_i};
        PosLenHi: begin
          if (len16 == '0 || {1'b0, len16} > MaxLen || len16 >= {3'b000, lim}) begin
            fail = 1'b1;
          end else begin
            len_d = len16[LenW-1:0];
          end
        end
        PosCrcLo:   hcrc_d = {8'h00, data_i};
        PosCrcHi:   hcrc_d = {data_i, hcrc_e[7:0]};
        default: begin
          if (pos_e >= HeaderBytes) begin
            crc_d = crc_new;
            if (pos_e == {1'b0, len_e} + PayloadEndOff) begin
              pass = (crc_new == hcrc_e);
              fail = (crc_new != hcrc_e);
            end
          end else if (pos_e >= PosSeqFirst && pos_e <= PosSeqLast) begin
            case (pos_e[1:0])
              2'd0:    seq_d[7:0]   = data_i;
              2'd1:    seq_d[15:8]  = data_i;
              2'd2:    seq_d[23:16] = data_i;
              default: seq_d[31:24] = data_i;
            endcase
          end
        end
      endcase
      if (!fail && !pass) begin
        pos_d = pos_e + 13'd1;
      end
    end
    judged_d = judged_e | fail | pass;
    slot_d   = slot_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      crc_q    <= '0;
      seq_q    <= '0;
      len_q    <= '0;
      hcrc_q   <= '0;
      judged_q <= 1'b1;
      slot_q   <= 1'b0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      seq_q    <= seq_d;
      len_q    <= len_d;
      hcrc_q   <= hcrc_d;
      judged_q <= judged_d;
      slot_q   <= slot_d;
    end
  end

  assign verdict_o.clear = start_i;
  assign verdict_o.done  = !judged_e && (fail || pass);
  assign verdict_o.ok    = pass;
  assign verdict_o.slot  = slot_e;
  assign verdict_o.seq   = seq_d;
  assign verdict_o.len   = len_d;

endmodule

`default_nettype wire

// ----- sv/abv_slot_sel.sv -----
// ----------------------------------------------------------------------------
// abv_slot_sel
// per-slot records and selection of the newest valid slot
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module abv_slot_sel (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire abv_pkg::verdict_t verdict_i,
  output abv_pkg::pick_t         pick_o
);
  import abv_pkg::*;

  logic [1:0] valid_q, valid_d;
  seq_t       seq_q [2];
  seq_t       seq_d [2];
  len_t       len_q [2];
  len_t       len_d [2];
  logic       pick1;

  always_comb begin
    valid_d = valid_q;
    seq_d   = seq_q;
    len_d   = len_q;
    if (verdict_i.clear) begin
      valid_d[verdict_i.slot] = 1'b0;
    end
    if (verdict_i.done && verdict_i.ok) begin
      valid_d[verdict_i.slot] = 1'b1;
      seq_d[verdict_i.slot]   = verdict_i.seq;
      len_d[verdict_i.slot]   = verdict_i.len;
    end

    // selection sees the records as this item leaves them
    pick1 = valid_d[1] && (!valid_d[0] || seq_d[1] > seq_d[0]);
    pick_o.any  = valid_d[0] | valid_d[1];
    pick_o.slot = pick1;
    if (pick1) begin
      pick_o.seq = seq_d[1];
      pick_o.len = len_d[1];
    end else if (valid_d[0]) begin
      pick_o.seq = seq_d[0];
      pick_o.len = len_d[0];
    end else begin
      pick_o.seq = '0;
      pick_o.len = '0;
    end
    pick_o.wr_slot = valid_d[0] && !pick1;
    pick_o.wr_seq  = pick_o.seq + 32'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (step_i) begin
      valid_q <= valid_d;
    end
  end

  // record contents are masked by the valid bits
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      seq_q <= seq_d;
      len_q <= len_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ab_slot_record_validator.sv -----
// ----------------------------------------------------------------------------
// ab_slot_record_validator
// checks a/b flash slot headers and payload crc, picks the newest slot
// ----------------------------------------------------------------------------
// usage:
//   the input channel carries one image byte per item with start_of_slot and
//   slot_index; the output channel returns one item per input item with the
//   verdict for that byte and the current slot selection.
//   payload_limit is written through cfg_we_i / cfg_wdata_i while idle.
// path: an accepted item sits in the input register and its result is loaded
//   into the output register once the output register is free or being taken.
// throughput: one item per cycle when not stalled; header parse, byte-wide crc
//   update and newest-slot compare all sit in the single process stage.
// reset: both slots invalid, no slot in progress, payload_limit 4096.
// stall: while an output item waits, the input register can still take one
//   item; in_ready_o then stays low until the output item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ab_slot_record_validator #(
  parameter int unsigned SLOT_BYTES = abv_pkg::SlotBytesDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire abv_pkg::limit_t        cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [7:0]             data_byte_i,
  input  wire logic                   start_of_slot_i,
  input  wire logic                   slot_index_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic                        verdict_ready_o,
  output logic                        slot_ok_o,
  output logic                        any_valid_o,
  output logic                        picked_slot_o,
  output abv_pkg::seq_t               picked_seq_o,
  output abv_pkg::len_t               picked_len_o,
  output logic                        write_slot_o,
  output abv_pkg::seq_t               write_seq_o
);
  import abv_pkg::*;

  `include "ab_slot_record_validator_macros.svh"

  limit_t     limit_q;
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       start_q;
  logic       idx_q;
  logic       out_valid_q;
  logic       advance;
  verdict_t   verdict;
  pick_t      pick;
  logic       pick_idle;
  logic       in_stall;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitRst;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q  <= data_byte_i;
      start_q <= start_of_slot_i;
      idx_q   <= slot_index_i;
    end
  end

  abv_hdr_parser #(
    .SLOT_BYTES(SLOT_BYTES)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .data_i    (byte_q),
    .start_i   (start_q),
    .idx_i     (idx_q),
    .limit_i   (limit_q),
    .verdict_o (verdict)
  );

  abv_slot_sel u_sel (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .verdict_i (verdict),
    .pick_o    (pick)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      verdict_ready_o <= verdict.done;
      slot_ok_o       <= verdict.done & verdict.ok;
      any_valid_o     <= pick.any;
      picked_slot_o   <= pick.slot;
      picked_seq_o    <= pick.seq;
      picked_len_o    <= pick.len;
      write_slot_o    <= pick.wr_slot;
      write_seq_o     <= pick.wr_seq;
    end
  end

  assign out_valid_o = out_valid_q;

  // selection outputs when no slot is valid
  assign pick_idle = !picked_slot_o && !write_slot_o && (picked_seq_o == '0) &&
                     (picked_len_o == '0) && (write_seq_o == 32'd1);
  assign in_stall  = in_valid_q && out_valid_q && !out_ready_i;

  `ABV_ASSERT_NOW(a_ok_needs_verdict, clk_i, rst_ni, out_valid_o && slot_ok_o, verdict_ready_o)
  `ABV_ASSERT_NOW(a_none_valid_defaults, clk_i, rst_ni, out_valid_o && !any_valid_o, pick_idle)
  `ABV_ASSERT_NEXT(a_stall_holds_item, clk_i, rst_ni, in_stall, in_valid_q && $stable({byte_q, start_q}))

endmodule

`default_nettype wire

// ----- tb/sv/ab_slot_record_validator_tb.sv -----
// ----------------------------------------------------------------------------
// ab_slot_record_validator_tb
// streams a/b slot images (good headers, broken headers, bad crc, cut images,
// stray bytes) through the validator under random idling on both channels,
// predicts every output item in the bench and compares it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ab_slot_record_validator_tb;
  import abv_pkg::*;

  localparam int MaxPayload = SlotBytesDef - 12;

  typedef enum {
    FLAW_NONE,
    FLAW_MAGIC_B,
    FLAW_MAGIC_C,
    FLAW_VERSION,
    FLAW_CRC,
    FLAW_CUT,
    FLAW_HDR_ONLY
  } image_flaw_e;

  typedef struct {
    logic [7:0] b;
    bit         sos;
    bit         idx;
  } slot_byte_t;

  typedef struct packed {
    logic verdict;
    logic ok;
    logic any;
    logic pslot;
    seq_t pseq;
    len_t plen;
    logic wslot;
    seq_t wseq;
  } slot_status_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  limit_t     cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_sos;
  logic       in_idx;
  logic       out_valid;
  logic       out_ready;
  logic       verdict_ready;
  logic       slot_ok;
  logic       any_valid;
  logic       picked_slot;
  seq_t       picked_seq;
  len_t       picked_len;
  logic       write_slot;
  seq_t       write_seq;

  // pending items and predicted output items
  slot_byte_t   byte_stream_q[$];
  slot_status_t status_q[$];
  slot_byte_t   next_byte;
  logic         in_took = 1'b0;
  int           sender_idle_pct = 37;
  int           recv_stall_pct = 50;
  int           fail_count = 0;
  seq_t         last_seq[2] = '{32'd0, 32'd0};

  // predictor state
  limit_t       pl_limit = LimitRst;
  logic [12:0]  pos = '0;
  logic [15:0]  crc_acc = '0;
  seq_t         hdr_seq = '0;
  logic [12:0]  hdr_len = '0;
  logic [15:0]  hdr_crc = '0;
  bit           judged = 1'b1;
  bit           cur_slot = 1'b0;
  bit           rec_valid[2] = '{1'b0, 1'b0};
  seq_t         rec_seq[2] = '{32'd0, 32'd0};
  logic [12:0]  rec_len[2] = '{13'd0, 13'd0};

  ab_slot_record_validator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (in_byte),
    .start_of_slot_i(in_sos),
    .slot_index_i   (in_idx),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .verdict_ready_o(verdict_ready),
    .slot_ok_o      (slot_ok),
    .any_valid_o    (any_valid),
    .picked_slot_o  (picked_slot),
    .picked_seq_o   (picked_seq),
    .picked_len_o   (picked_len),
    .write_slot_o   (write_slot),
    .write_seq_o    (write_seq)
  );

  always #5 clk_i = ~clk_i;

  // crc-16 xmodem, one data bit at a time
  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
    end
    return c;
  endfunction

  task automatic predict_status(input logic [7:0] b, input bit sos, input bit idx);
    slot_status_t st;
    bit           is_fail;
    bit           is_pass;
    logic [15:0]  len16;
    limit_t       lim;
    int           sh;
    int           newest;
    is_fail = 1'b0;
    is_pass = 1'b0;
    st = '0;
    if (sos) begin
      cur_slot = idx;
      rec_valid[idx] = 1'b0;
      pos = '0;
      crc_acc = '0;
      hdr_seq = '0;
      hdr_len = '0;
      hdr_crc = '0;
      judged = 1'b0;
    end
    if (!judged) begin
      if (pos == PosMagic0) begin
        is_fail = (b != MagicB);
      end else if (pos == PosMagic1) begin
        is_fail = (b != MagicC);
      end else if (pos == PosVersion) begin
        is_fail = (b != HdrVersion);
      end else if (pos >= PosSeqFirst && pos <= PosSeqLast) begin
        sh = 8 * int'(pos - PosSeqFirst);
        hdr_seq = hdr_seq | (seq_t'(b) << sh);
      end else if (pos == PosLenLo) begin
        hdr_len = 13'(b);
      end else if (pos == PosLenHi) begin
        len16 = {b, hdr_len[7:0]};
        lim = (pl_limit > LimitCap) ? LimitCap : pl_limit;
        if (len16 == 16'd0 || len16 > MaxPayload || len16 >= lim) begin
          is_fail = 1'b1;
        end else begin
          hdr_len = len16[12:0];
        end
      end else if (pos == PosCrcLo) begin
        hdr_crc = 16'(b);
      end else if (pos == PosCrcHi) begin
        hdr_crc[15:8] = b;
      end else if (pos >= HeaderBytes) begin
        crc_acc = crc16_update(crc_acc, b);
        if (13'(pos - HeaderBytes + 13'd1) == hdr_len) begin
          is_pass = (crc_acc == hdr_crc);
          is_fail = !is_pass;
        end
      end
      if (is_fail || is_pass) begin
        st.verdict = 1'b1;
        st.ok = is_pass;
        judged = 1'b1;
        if (is_pass) begin
          rec_valid[cur_slot] = 1'b1;
          rec_seq[cur_slot] = hdr_seq;
          rec_len[cur_slot] = hdr_len;
        end
      end else begin
        pos = pos + 13'd1;
      end
    end
    newest = -1;
    if (rec_valid[0]) newest = 0;
    if (rec_valid[1] && (!rec_valid[0] || rec_seq[1] > rec_seq[0])) newest = 1;
    st.any = (newest >= 0);
    st.pslot = (newest == 1);
    st.pseq = (newest >= 0) ? rec_seq[newest] : '0;
    st.plen = (newest >= 0) ? rec_len[newest][11:0] : '0;
    st.wslot = (newest == 0);
    st.wseq = st.pseq + 32'd1;
    status_q.push_back(st);
  endtask

  function automatic bit field_ok(input string name, input logic [31:0] exp_v,
                                  input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s mismatch: expected %0h got %0h", $time, name, exp_v, act_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic check_status();
    slot_status_t e;
    bit           good;
    if (status_q.size() == 0) begin
      $display("%0t output item with none expected", $time);
      fail_count++;
    end else begin
      e = status_q.pop_front();
      good = 1'b1;
      good &= field_ok("verdict_ready", 32'(e.verdict), 32'(verdict_ready));
      good &= field_ok("slot_ok", 32'(e.ok), 32'(slot_ok));
      good &= field_ok("any_valid", 32'(e.any), 32'(any_valid));
      good &= field_ok("picked_slot", 32'(e.pslot), 32'(picked_slot));
      good &= field_ok("picked_seq", e.pseq, picked_seq);
      good &= field_ok("picked_len", 32'(e.plen), 32'(picked_len));
      good &= field_ok("write_slot", 32'(e.wslot), 32'(write_slot));
      good &= field_ok("write_seq", e.wseq, write_seq);
      if (!good) fail_count++;
    end
  endtask

  // driver: new item or idle only once the held item has gone
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_took) begin
        if (byte_stream_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_byte = byte_stream_q.pop_front();
          in_valid <= 1'b1;
          in_byte <= next_byte.b;
          in_sos <= next_byte.sos;
          in_idx <= next_byte.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor: predict on input accept, then check the output item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) predict_status(in_byte, in_sos, in_idx);
      if (out_valid && out_ready) check_status();
    end else begin
      in_took <= 1'b0;
    end
  end

  function automatic seq_t pick_seq(input bit slot);
    seq_t other;
    other = last_seq[~slot];
    case ($urandom_range(0, 9))
      0: return other;
      1: return other + 32'd1;
      2: return other - 32'd1;
      3: return 32'hFFFF_FFFF;
      4: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_len();
    case ($urandom_range(0, 19))
      0: return 16'd0;
      1: return 16'($urandom_range(MaxPayload + 1, 65535));
      2: return 16'(pl_limit) - 16'd1;
      3: return 16'(pl_limit);
      4: return 16'(pl_limit) + 16'd1;
      5: return {8'($urandom_range(16, 255)), 8'($urandom)};
      default: return 16'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic image_flaw_e pick_flaw();
    case ($urandom_range(0, 19))
      0: return FLAW_MAGIC_B;
      1: return FLAW_MAGIC_C;
      2: return FLAW_VERSION;
      3, 4: return FLAW_CRC;
      5, 6: return FLAW_CUT;
      default: return FLAW_NONE;
    endcase
  endfunction

  // queue one slot image, with stray bytes after it
  task automatic add_image(input bit slot, input seq_t seq, input logic [15:0] len,
                           input image_flaw_e flaw);
    logic [7:0]  img[$];
    logic [7:0]  b;
    logic [15:0] crc;
    int          n;
    int          cut;
    limit_t      lim;
    slot_byte_t  sb;
    lim = (pl_limit > LimitCap) ? LimitCap : pl_limit;
    n = (len != 16'd0 && len <= MaxPayload && len < lim) ? int'(len) : $urandom_range(0, 3);
    img.push_back(MagicB);
    img.push_back(MagicC);
    img.push_back(HdrVersion);
    img.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) img.push_back(seq[8*i +: 8]);
    img.push_back(len[7:0]);
    img.push_back(len[15:8]);
    img.push_back(8'h00);
    img.push_back(8'h00);
    crc = '0;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      crc = crc16_update(crc, b);
      img.push_back(b);
    end
    if (flaw == FLAW_CRC) crc = crc ^ 16'(1 << $urandom_range(0, 15));
    img[10] = crc[7:0];
    img[11] = crc[15:8];
    if (flaw == FLAW_MAGIC_B) img[0] = img[0] ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_MAGIC_C) img[1] = img[1] ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_VERSION) img[2] = img[2] ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_CUT) begin
      cut = $urandom_range(1, img.size() - 1);
      while (img.size() > cut) void'(img.pop_back());
    end
    // header alone, so the length check shows without the whole payload
    if (flaw == FLAW_HDR_ONLY) begin
      while (img.size() > int'(HeaderBytes)) void'(img.pop_back());
    end
    for (int i = 0; i < img.size(); i++) begin
      sb.b = img[i];
      sb.sos = (i == 0);
      // index is only meaningful at the start byte
      sb.idx = (i != 0 && $urandom_range(0, 4) == 0) ? ~slot : slot;
      byte_stream_q.push_back(sb);
    end
    if (flaw != FLAW_CUT) begin
      repeat ($urandom_range(0, 2)) begin
        sb.b = 8'($urandom);
        sb.sos = 1'b0;
        sb.idx = 1'($urandom);
        byte_stream_q.push_back(sb);
      end
    end
    last_seq[slot] = seq;
  endtask

  task automatic wait_drained();
    while (byte_stream_q.size() != 0 || in_valid || status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input limit_t v);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    pl_limit = v;
  endtask

  task automatic run_phase(input limit_t lim, input int sidle, input int rstall,
                           input int budget);
    bit slot;
    wait_drained();
    write_limit(lim);
    sender_idle_pct = sidle;
    recv_stall_pct = rstall;
    while (byte_stream_q.size() < budget) begin
      slot = 1'($urandom);
      add_image(slot, pick_seq(slot), pick_len(), pick_flaw());
    end
  endtask

  initial begin
    slot_byte_t sb;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_byte = '0;
    in_sos = 1'b0;
    in_idx = 1'b0;
    out_ready = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // bytes before any start are ignored
    sb.sos = 1'b0;
    sb.b = 8'h00;
    sb.idx = 1'b1;
    byte_stream_q.push_back(sb);
    sb.b = 8'hFF;
    sb.idx = 1'b0;
    byte_stream_q.push_back(sb);
    // minimum length, top sequence so the next save wraps to 0
    add_image(1'b0, 32'hFFFF_FFFF, 16'd1, FLAW_NONE);
    add_image(1'b1, 32'h0000_0001, 16'd1, FLAW_MAGIC_B);
    // equal sequence numbers keep slot 0
    add_image(1'b1, 32'hFFFF_FFFF, 16'd1, FLAW_NONE);

    run_phase(limit_t'(1), 37, 50, 150);
    run_phase(limit_t'(13), 37, 50, 300);
    run_phase(limit_t'(0), 50, 37, 100);
    run_phase(limit_t'(8191), 50, 37, 300);
    // one full-size header that passes the length check and one a byte too long
    add_image(1'b1, pick_seq(1'b1), 16'(MaxPayload), FLAW_HDR_ONLY);
    add_image(1'b0, pick_seq(1'b0), 16'(MaxPayload + 1), FLAW_NONE);
    run_phase(limit_t'(4096), 0, 0, 300);
    run_phase(limit_t'(4095), 0, 0, 300);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ab_slot_record_validator_tb passed");
    end else begin
      $display("ab_slot_record_validator_tb failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("ab_slot_record_validator_tb failed");
    $finish;
  end

endmodule
